// File: rtl/core/dsvp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvp_pkg
// Shared types and constants of the delimiter-separated byte parser.
// ----------------------------------------------------------------------------
package dsvp_pkg;

    // Upper bound on the column count in use
    localparam logic [15:0] MaxColumns = 16'd255;

    // Largest legal table index
    localparam logic [34:0] IndexMax = 35'h0_7FFF_FFFF;

    // Result buffer depth: most results one item can cause
    localparam int MaxResults = 3;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ESCAPE_SYMBOL    = 3'd0,
        REG_FIELD_SEPARATOR  = 3'd1,
        REG_RECORD_SEPARATOR = 3'd2,
        REG_TABLE_INDEX_EN   = 3'd3,
        REG_COLUMN_COUNT     = 3'd4,
        REG_UNESCAPE_PAIRS   = 3'd5
    } reg_index_t;

    // Result event codes
    typedef enum logic [3:0] {
        EV_DATA         = 4'd0,
        EV_RECORD_BEGIN = 4'd1,
        EV_FIELD_END    = 4'd2,
        EV_RECORD_END   = 4'd3,
        EV_TABLE_SWITCH = 4'd4,
        EV_INCOMPLETE   = 4'd5,
        EV_UNFINISHED   = 4'd6,
        EV_FINISH_OK    = 4'd7,
        EV_BAD_INDEX    = 4'd8,
        EV_EXTRA_FIELD  = 4'd9
    } event_t;

    // Input item kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // One buffered result (row number is shared by all results of an item)
    typedef struct packed {
        event_t      ev;
        logic [7:0]  data;
        logic [7:0]  col;
        logic [30:0] tab;
    } result_t;

    function automatic result_t make_result(event_t ev, logic [7:0] data,
                                            logic [7:0] col, logic [30:0] tab);
        result_t r;
        r.ev   = ev;
        r.data = data;
        r.col  = col;
        r.tab  = tab;
        return r;
    endfunction

endpackage

// File: rtl/core/dsvp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvp_in_if
// Input channel: one text byte or a finish marker per item.
// ----------------------------------------------------------------------------
interface dsvp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// File: rtl/core/dsvp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvp_out_if
// Result channel: parser events with column, table and row information.
// ----------------------------------------------------------------------------
interface dsvp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [7:0]  out_byte;
    logic [7:0]  column;
    logic [30:0] table_number;
    logic [31:0] row_number;
    logic        last;

    modport source (output valid, output event_res, output out_byte, output column,
                    output table_number, output row_number, output last, input ready);
    modport sink   (input valid, input event_res, input out_byte, input column,
                    input table_number, input row_number, input last, output ready);
endinterface

// File: rtl/core/schemed_dsv_byte_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schemed_dsv_byte_parser
// Fixed-column delimiter-separated text parser with escapes and table index.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------------------
//  text     | in  | valid / ready  | kind, data_byte
//  result   | out | valid / ready  | event_res, out_byte, column,
//           |     |                | table_number, row_number, last
//  cfg      | in  | cfg_we         | cfg_index, cfg_data (64 bits)
//
//  An accepted item is parsed in the same cycle; its 0 to 3 results land in a
//  result buffer and leave one per cycle while result.ready is high, from the
//  next cycle on. Items with at most one result sustain one item per cycle
//  while result.ready is high; the buffer drain sets the rate, so an item with
//  more results holds the input. A new item is taken while the last buffered
//  result is being handed over. rst_n clears the parser state, buffer level and
//  configuration registers, not the result payload; no clearing pass is needed.
// ----------------------------------------------------------------------------
module schemed_dsv_byte_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    dsvp_in_if.sink     text,
    dsvp_out_if.source  result
);
    import dsvp_pkg::*;

    // Configuration registers
    logic [7:0]  escape_symbol_reg;
    logic [7:0]  field_separator_reg;
    logic [7:0]  record_separator_reg;
    logic        table_index_en_reg;
    logic [7:0]  column_count_reg;
    logic [63:0] unescape_pairs_reg;

    // Parser state
    logic        escape_pending_reg, escape_pending_next;
    logic        record_open_reg, record_open_next;
    logic        token_nonempty_reg, token_nonempty_next;
    logic [7:0]  field_count_reg, field_count_next;
    logic [30:0] current_table_reg, current_table_next;
    logic [30:0] index_acc_reg, index_acc_next;
    logic        index_invalid_reg, index_invalid_next;
    logic [31:0] row_count_reg, row_count_next;

    // Result buffer
    result_t     res_reg [MaxResults];
    result_t     res_next [MaxResults];
    logic [1:0]  res_left_reg, res_left_next;
    logic [31:0] res_row_reg;

    logic        in_take;
    logic        out_take;
    logic [7:0]  cols;
    logic [15:0] cols_wide;
    logic [1:0]  n_v;
    logic [7:0]  ch;
    logic [7:0]  unesc;
    logic        is_digit;
    logic [34:0] acc_prod;
    logic        do_take;
    logic        do_sep;
    logic        sep_is_record;

    // Handshakes
    assign out_take    = result.valid && result.ready;
    assign text.ready  = (res_left_reg == 2'd0) || ((res_left_reg == 2'd1) && result.ready);
    assign in_take     = text.valid && text.ready;

    // Result port
    assign result.valid        = (res_left_reg != 2'd0);
    assign result.event_res    = res_reg[0].ev;
    assign result.out_byte     = res_reg[0].data;
    assign result.column       = res_reg[0].col;
    assign result.table_number = res_reg[0].tab;
    assign result.row_number   = res_row_reg;
    assign result.last         = (res_left_reg == 2'd1);

    // Column count in use
    assign cols_wide = ({8'd0, column_count_reg} < MaxColumns) ?
                       {8'd0, column_count_reg} : MaxColumns;
    assign cols      = cols_wide[7:0];

    // Unescape map: lowest matching pair wins
    always_comb
    begin
        unesc = text.data_byte;
        for (int k = 3; k >= 0; k--)
        begin
            if (unescape_pairs_reg[16*k+8 +: 8] == text.data_byte)
            begin
                unesc = unescape_pairs_reg[16*k +: 8];
            end
        end
    end

    // Classify the byte
    always_comb
    begin
        do_take       = 1'b0;
        do_sep        = 1'b0;
        sep_is_record = 1'b0;
        ch            = text.data_byte;
        if (escape_pending_reg)
        begin
            do_take = 1'b1;
            ch      = unesc;
        end
        else if (text.data_byte == escape_symbol_reg)
        begin
            do_take = 1'b0;
        end
        else if (text.data_byte == record_separator_reg)
        begin
            do_sep        = 1'b1;
            sep_is_record = 1'b1;
        end
        else if (text.data_byte == field_separator_reg)
        begin
            do_sep = 1'b1;
        end
        else
        begin
            do_take = 1'b1;
        end
    end

    // Index digit accumulate: acc * 10 + digit
    assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign acc_prod = ({4'd0, index_acc_reg} << 3) + ({4'd0, index_acc_reg} << 1)
                    + {31'd0, ch[3:0] - 4'h0};

    // Next state and results of one item
    always_comb
    begin
        escape_pending_next = escape_pending_reg;
        record_open_next    = record_open_reg;
        token_nonempty_next = token_nonempty_reg;
        field_count_next    = field_count_reg;
        current_table_next  = current_table_reg;
        index_acc_next      = index_acc_reg;
        index_invalid_next  = index_invalid_reg;
        row_count_next      = row_count_reg;
        n_v                 = 2'd0;
        for (int i = 0; i < MaxResults; i++)
        begin
            res_next[i] = make_result(EV_DATA, 8'd0, 8'd0, 31'd0);
        end

        if (text.kind == KIND_FINISH)
        begin
            if (record_open_reg || token_nonempty_reg || escape_pending_reg)
            begin
                res_next[0] = make_result(EV_UNFINISHED, 8'd0, 8'd0, 31'd0);
            end
            else
            begin
                res_next[0] = make_result(EV_FINISH_OK, 8'd0, 8'd0, 31'd0);
            end
            n_v                 = 2'd1;
            token_nonempty_next = 1'b0;
            index_acc_next      = 31'd0;
            index_invalid_next  = 1'b0;
        end
        else
        begin
            // Record opens on its first byte when no index is read
            if (!table_index_en_reg && !record_open_reg)
            begin
                res_next[n_v]    = make_result(EV_RECORD_BEGIN, 8'd0, 8'd0, 31'd0);
                n_v              = n_v + 2'd1;
                record_open_next = 1'b1;
            end

            if (escape_pending_reg)
            begin
                escape_pending_next = 1'b0;
            end
            else if (text.data_byte == escape_symbol_reg)
            begin
                escape_pending_next = 1'b1;
            end

            if (do_take)
            begin
                token_nonempty_next = 1'b1;
                if (table_index_en_reg && !record_open_next)
                begin
                    if (!index_invalid_reg)
                    begin
                        if (is_digit && (acc_prod <= IndexMax))
                        begin
                            index_acc_next = acc_prod[30:0];
                        end
                        else
                        begin
                            index_invalid_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    res_next[n_v] = make_result(EV_DATA, ch, 8'd0, 31'd0);
                    n_v           = n_v + 2'd1;
                end
            end
            else if (do_sep)
            begin
                if (!record_open_next)
                begin
                    // Index token ends
                    if (index_invalid_reg || !token_nonempty_reg)
                    begin
                        res_next[n_v] = make_result(EV_BAD_INDEX, 8'd0, 8'd0, 31'd0);
                        n_v           = n_v + 2'd1;
                    end
                    else if (index_acc_reg != current_table_reg)
                    begin
                        current_table_next = index_acc_reg;
                        res_next[n_v]      = make_result(EV_TABLE_SWITCH, 8'd0, 8'd0,
                                                         index_acc_reg);
                        n_v                = n_v + 2'd1;
                    end
                    res_next[n_v]       = make_result(EV_RECORD_BEGIN, 8'd0, 8'd0, 31'd0);
                    n_v                 = n_v + 2'd1;
                    record_open_next    = 1'b1;
                    token_nonempty_next = 1'b0;
                    index_acc_next      = 31'd0;
                    index_invalid_next  = 1'b0;
                end
                else
                begin
                    if (field_count_reg < cols)
                    begin
                        res_next[n_v]    = make_result(EV_FIELD_END, 8'd0, field_count_reg,
                                                       31'd0);
                        field_count_next = field_count_reg + 8'd1;
                    end
                    else
                    begin
                        res_next[n_v] = make_result(EV_EXTRA_FIELD, 8'd0, 8'd0, 31'd0);
                    end
                    n_v                 = n_v + 2'd1;
                    token_nonempty_next = 1'b0;
                    if (sep_is_record)
                    begin
                        if (field_count_next < cols)
                        begin
                            res_next[n_v] = make_result(EV_INCOMPLETE, 8'd0, 8'd0, 31'd0);
                        end
                        else
                        begin
                            res_next[n_v] = make_result(EV_RECORD_END, 8'd0, 8'd0, 31'd0);
                        end
                        n_v              = n_v + 2'd1;
                        record_open_next = 1'b0;
                        field_count_next = 8'd0;
                        row_count_next   = row_count_reg + 32'd1;
                    end
                end
            end
        end
    end

    // Buffer fill level
    always_comb
    begin
        res_left_next = res_left_reg;
        if (in_take)
        begin
            res_left_next = n_v;
        end
        else if (out_take)
        begin
            res_left_next = res_left_reg - 2'd1;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_symbol_reg    <= 8'd92;
            field_separator_reg  <= 8'd9;
            record_separator_reg <= 8'd10;
            table_index_en_reg   <= 1'b0;
            column_count_reg     <= 8'd1;
            unescape_pairs_reg   <= 64'd0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_ESCAPE_SYMBOL:    escape_symbol_reg    <= cfg_data[7:0];
                REG_FIELD_SEPARATOR:  field_separator_reg  <= cfg_data[7:0];
                REG_RECORD_SEPARATOR: record_separator_reg <= cfg_data[7:0];
                REG_TABLE_INDEX_EN:   table_index_en_reg   <= cfg_data[0];
                REG_COLUMN_COUNT:     column_count_reg     <= cfg_data[7:0];
                REG_UNESCAPE_PAIRS:   unescape_pairs_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Parser state and buffer level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
            record_open_reg    <= 1'b0;
            token_nonempty_reg <= 1'b0;
            field_count_reg    <= 8'd0;
            current_table_reg  <= 31'd0;
            index_acc_reg      <= 31'd0;
            index_invalid_reg  <= 1'b0;
            row_count_reg      <= 32'd0;
            res_left_reg       <= 2'd0;
        end
        else
        begin
            res_left_reg <= res_left_next;
            if (in_take)
            begin
                escape_pending_reg <= escape_pending_next;
                record_open_reg    <= record_open_next;
                token_nonempty_reg <= token_nonempty_next;
                field_count_reg    <= field_count_next;
                current_table_reg  <= current_table_next;
                index_acc_reg      <= index_acc_next;
                index_invalid_reg  <= index_invalid_next;
                row_count_reg      <= row_count_next;
            end
        end
    end

    // Result payload: load on a new item, shift down as results leave
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int i = 0; i < MaxResults; i++)
            begin
                res_reg[i] <= res_next[i];
            end
            res_row_reg <= row_count_reg;
        end
        else if (out_take)
        begin
            for (int i = 0; i < MaxResults - 1; i++)
            begin
                res_reg[i] <= res_reg[i+1];
            end
        end
    end

    // Checks
    a_finish_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (text.kind == KIND_FINISH)) |=>
            (result.valid && result.last &&
             ((result.event_res == EV_UNFINISHED) || (result.event_res == EV_FINISH_OK))))
        else $error("finish item did not give a single finish result");

    a_accept_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> ((res_left_reg == 2'd0) || ((res_left_reg == 2'd1) && out_take)))
        else $error("item accepted over undelivered results");

    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (row_count_reg != $past(row_count_reg)) |->
            ((row_count_reg == $past(row_count_reg) + 32'd1) && $past(in_take)))
        else $error("row count moved by more than one record");

endmodule
